>>> rtl/fdnr_pkg.sv
// ----------------------------------------------------------------------------
// fdnr_pkg
// Shared constants, codes, control types and helper functions of the
// four-line feedback delay network reverb.
// ----------------------------------------------------------------------------
package fdnr_pkg;

  localparam int LINES       = 4;
  localparam int LINE_DEPTH  = 65536;
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_W    = 16;

  localparam int POS_W       = $clog2(LINE_DEPTH);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LINE_W      = $clog2(LINES);
  localparam int MEM_DEPTH   = LINES * CHANNELS * LINE_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  localparam int DELAY_W     = 16;
  localparam int GAIN_W      = 17;
  localparam int UNITY       = 32768;
  localparam int FRAC        = 15;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int WET_W       = DIFF_W + 3;
  localparam int OPA_W       = WET_W;
  localparam int PROD_W      = OPA_W + GAIN_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int SAT_IN_W    = SAMPLE_W + 8;

  localparam int CNT_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DELAY_W-1:0]    DELAY_ONE_RST   = 16'd2880;
  localparam logic [DELAY_W-1:0]    DELAY_TWO_RST   = 16'd2544;
  localparam logic [DELAY_W-1:0]    DELAY_THREE_RST = 16'd2928;
  localparam logic [DELAY_W-1:0]    DELAY_FOUR_RST  = 16'd4656;
  localparam logic [CFG_DATA_W-1:0] GAINS_A_RST     = 32'h4CCD_2666;
  localparam logic [CFG_DATA_W-1:0] GAINS_B_RST     = 32'h3333_4000;
  localparam logic [DELAY_W-1:0]    MASTER_MIX_RST  = 16'd19661;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_ONE   = 3'd0,
    REG_DELAY_TWO   = 3'd1,
    REG_DELAY_THREE = 3'd2,
    REG_DELAY_FOUR  = 3'd3,
    REG_GAINS_A     = 3'd4,
    REG_GAINS_B     = 3'd5,
    REG_MASTER_MIX  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_HADAMARD,
    ST_MAC,
    ST_MIX,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_TAP,
    MUL_DRY,
    MUL_WET
  } mul_sel_e;

  typedef struct packed {
    logic                    load_in;
    logic                    rd_en;
    logic                    wr_en;
    logic                    had_en;
    logic                    mul_en;
    mul_sel_e                mul_sel;
    logic                    acc_clr;
    logic                    acc_en;
    logic                    wet_en;
    logic                    y_en;
    logic                    out_load;
    logic [LINE_W-1:0]       line;
  } ctl_cmd_t;

  typedef struct packed {
    logic [LINES-1:0][POS_W-1:0]  delay;
    logic [LINES-1:0][GAIN_W-1:0] gain;
    logic [GAIN_W-1:0]            master;
  } cfg_t;

  function automatic logic [POS_W-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
    logic [POS_W-1:0] r;
    if (d == '0) begin
      r = POS_W'(1);
    end else if (32'(d) > LINE_DEPTH - 1) begin
      r = POS_W'(LINE_DEPTH - 1);
    end else begin
      r = POS_W'(d);
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [DELAY_W-1:0] g);
    logic [GAIN_W-1:0] r;
    if (32'(g) > UNITY) begin
      r = GAIN_W'(UNITY);
    end else begin
      r = GAIN_W'(g);
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] r;
    hi = SAT_IN_W'((1 << (SAMPLE_W - 1)) - 1);
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) begin
      r = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      r = lo[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(
    input logic [LINE_W-1:0] line,
    input logic [CH_W-1:0]   ch,
    input logic [POS_W-1:0]  pos
  );
    int base;
    base = (int'(line) * CHANNELS + int'(ch)) * LINE_DEPTH + int'(pos);
    return ADDR_W'(base);
  endfunction

endpackage

>>> rtl/fdnr_cfg.sv
// ----------------------------------------------------------------------------
// fdnr_cfg
// Configuration register file: delays, line gains and master mix, with
// clamping of out-of-range delays and gains.
// ----------------------------------------------------------------------------
module fdnr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fdnr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fdnr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output fdnr_pkg::cfg_t                   cfg_o
);

  logic [fdnr_pkg::DELAY_W-1:0]    delay_q [fdnr_pkg::LINES];
  logic [fdnr_pkg::DELAY_W-1:0]    delay_d [fdnr_pkg::LINES];
  logic [fdnr_pkg::CFG_DATA_W-1:0] gains_a_q, gains_a_d;
  logic [fdnr_pkg::CFG_DATA_W-1:0] gains_b_q, gains_b_d;
  logic [fdnr_pkg::DELAY_W-1:0]    master_q, master_d;
  fdnr_pkg::cfg_reg_e              reg_idx;

  assign cfg_ready_o = 1'b1;
  assign reg_idx     = fdnr_pkg::cfg_reg_e'(cfg_index_i);

  always_comb begin
    delay_d   = delay_q;
    gains_a_d = gains_a_q;
    gains_b_d = gains_b_q;
    master_d  = master_q;
    if (cfg_valid_i) begin
      unique case (reg_idx) inside
        fdnr_pkg::REG_DELAY_ONE, fdnr_pkg::REG_DELAY_TWO,
        fdnr_pkg::REG_DELAY_THREE, fdnr_pkg::REG_DELAY_FOUR: begin
          delay_d[cfg_index_i[fdnr_pkg::LINE_W-1:0]] = cfg_data_i[fdnr_pkg::DELAY_W-1:0];
        end
        fdnr_pkg::REG_GAINS_A: begin
          gains_a_d = cfg_data_i;
        end
        fdnr_pkg::REG_GAINS_B: begin
          gains_b_d = cfg_data_i;
        end
        fdnr_pkg::REG_MASTER_MIX: begin
          master_d = cfg_data_i[fdnr_pkg::DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q[0] <= fdnr_pkg::DELAY_ONE_RST;
      delay_q[1] <= fdnr_pkg::DELAY_TWO_RST;
      delay_q[2] <= fdnr_pkg::DELAY_THREE_RST;
      delay_q[3] <= fdnr_pkg::DELAY_FOUR_RST;
      gains_a_q  <= fdnr_pkg::GAINS_A_RST;
      gains_b_q  <= fdnr_pkg::GAINS_B_RST;
      master_q   <= fdnr_pkg::MASTER_MIX_RST;
    end else begin
      delay_q    <= delay_d;
      gains_a_q  <= gains_a_d;
      gains_b_q  <= gains_b_d;
      master_q   <= master_d;
    end
  end

  always_comb begin
    for (int k = 0; k < fdnr_pkg::LINES; k++) begin
      cfg_o.delay[k] = fdnr_pkg::clamp_delay(delay_q[k]);
    end
    cfg_o.gain[0] = fdnr_pkg::clamp_gain(gains_a_q[15:0]);
    cfg_o.gain[1] = fdnr_pkg::clamp_gain(gains_a_q[31:16]);
    cfg_o.gain[2] = fdnr_pkg::clamp_gain(gains_b_q[15:0]);
    cfg_o.gain[3] = fdnr_pkg::clamp_gain(gains_b_q[31:16]);
    cfg_o.master  = fdnr_pkg::clamp_gain(master_q);
  end

endmodule

>>> rtl/fdnr_ctrl.sv
// ----------------------------------------------------------------------------
// fdnr_ctrl
// Sequencer: steps one sample through tap reads, Hadamard mix, gain
// multiply-accumulate, dry/wet mix and line write-back; owns both handshakes.
// ----------------------------------------------------------------------------
module fdnr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fdnr_pkg::ctl_cmd_t cmd_o
);

  localparam logic [fdnr_pkg::CNT_W-1:0] CNT_LAST = fdnr_pkg::CNT_W'(fdnr_pkg::LINES - 1);
  localparam logic [fdnr_pkg::CNT_W-1:0] CNT_TAIL = fdnr_pkg::CNT_W'(fdnr_pkg::LINES);

  fdnr_pkg::state_e              state_q, state_d;
  logic [fdnr_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  fdnr_pkg::ctl_cmd_t            cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdnr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    cmd.line   = cnt_q[fdnr_pkg::LINE_W-1:0];
    in_ready_o = 1'b0;
    unique case (state_q)
      fdnr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          cnt_d       = '0;
          state_d     = fdnr_pkg::ST_READ;
        end
      end
      fdnr_pkg::ST_READ: begin
        cmd.rd_en = (cnt_q < CNT_TAIL);
        if (cnt_q == CNT_TAIL) begin
          cnt_d   = '0;
          state_d = fdnr_pkg::ST_HADAMARD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      fdnr_pkg::ST_HADAMARD: begin
        cmd.had_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_d     = fdnr_pkg::ST_MAC;
      end
      fdnr_pkg::ST_MAC: begin
        cmd.mul_en  = (cnt_q < CNT_TAIL);
        cmd.mul_sel = fdnr_pkg::MUL_TAP;
        cmd.acc_en  = (cnt_q != '0);
        if (cnt_q == CNT_TAIL) begin
          cnt_d   = '0;
          state_d = fdnr_pkg::ST_MIX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      fdnr_pkg::ST_MIX: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q)
          3'd0: begin
            cmd.wet_en  = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = fdnr_pkg::MUL_DRY;
          end
          3'd1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = fdnr_pkg::MUL_WET;
            cmd.acc_en  = 1'b1;
          end
          3'd2: begin
            cmd.acc_en = 1'b1;
          end
          default: begin
            cmd.y_en = 1'b1;
            cnt_d    = '0;
            state_d  = fdnr_pkg::ST_WRITE;
          end
        endcase
      end
      fdnr_pkg::ST_WRITE: begin
        cmd.wr_en = 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = fdnr_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      fdnr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = fdnr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdnr_pkg::ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd_en && cmd.wr_en))
    else $error("memory read and write issued together");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == fdnr_pkg::ST_READ && cnt_q == '0))
    else $error("accepted sample did not start the tap reads");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == fdnr_pkg::ST_DONE))
    else $error("result raised outside the final step");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_TAIL)
    else $error("step counter out of range");
`endif

endmodule

>>> rtl/fdnr_datapath.sv
// ----------------------------------------------------------------------------
// fdnr_datapath
// Delay store, write positions, tap registers, Hadamard mixer, shared
// multiplier with accumulator, saturation and the output register.
// ----------------------------------------------------------------------------
module fdnr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdnr_pkg::ctl_cmd_t                  cmd_i,
  input  fdnr_pkg::cfg_t                      cfg_i,
  input  logic                                channel_i,
  input  logic signed [fdnr_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic signed [fdnr_pkg::SAMPLE_W-1:0] sample_out_o
);

  localparam int SW = fdnr_pkg::SAMPLE_W;

  logic [SW-1:0]                      store_mem [fdnr_pkg::MEM_DEPTH];
  logic [SW-1:0]                      rdata_q;

  logic [fdnr_pkg::POS_W-1:0]         wp_q   [fdnr_pkg::CHANNELS];
  logic [fdnr_pkg::CHANNELS-1:0]      wrap_q;

  logic signed [SW-1:0]               x_q;
  logic [fdnr_pkg::CH_W-1:0]          ch_q, ch_d;
  logic                               rd_pend_q;
  logic                               rd_ok_q;
  logic [fdnr_pkg::LINE_W-1:0]        rd_line_q;
  logic signed [SW-1:0]               t_q    [fdnr_pkg::LINES];
  logic signed [fdnr_pkg::DIFF_W-1:0] d_q    [fdnr_pkg::LINES];
  logic signed [fdnr_pkg::PROD_W-1:0] prod_q;
  logic signed [fdnr_pkg::ACC_W-1:0]  acc_q;
  logic signed [fdnr_pkg::WET_W-1:0]  wet_q;
  logic signed [SW-1:0]               y_q;
  logic signed [SW-1:0]               out_q;

  logic [fdnr_pkg::POS_W-1:0]         wp;
  logic                               rd_ok;
  logic [fdnr_pkg::ADDR_W-1:0]        raddr, waddr;
  logic signed [SW+1:0]               e     [fdnr_pkg::LINES];
  logic signed [SW+1:0]               s     [fdnr_pkg::LINES];
  logic signed [fdnr_pkg::OPA_W-1:0]  op_a;
  logic signed [fdnr_pkg::GAIN_W-1:0] op_b;
  logic signed [SW+1:0]               wsum;
  logic signed [SW-1:0]               wval;
  logic signed [fdnr_pkg::SAT_IN_W-1:0] y_pre;

  assign ch_d = (32'(channel_i) > fdnr_pkg::CHANNELS - 1)
              ? fdnr_pkg::CH_W'(fdnr_pkg::CHANNELS - 1)
              : fdnr_pkg::CH_W'(channel_i);

  assign wp    = wp_q[ch_q];
  assign rd_ok = wrap_q[ch_q] || (wp >= cfg_i.delay[cmd_i.line]);
  assign raddr = fdnr_pkg::mem_addr(cmd_i.line, ch_q, wp - cfg_i.delay[cmd_i.line]);
  assign waddr = fdnr_pkg::mem_addr(cmd_i.line, ch_q, wp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_mem[waddr] <= wval;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      wrap_q    <= '0;
      for (int c = 0; c < fdnr_pkg::CHANNELS; c++) begin
        wp_q[c] <= '0;
      end
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      if (cmd_i.out_load) begin
        wp_q[ch_q] <= wp + 1'b1;
        if (wp == fdnr_pkg::POS_W'(fdnr_pkg::LINE_DEPTH - 1)) begin
          wrap_q[ch_q] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < fdnr_pkg::LINES; k++) begin
      e[k] = (SW + 2)'(t_q[k]);
    end
    s[0] = e[0] + e[1] + e[2] + e[3];
    s[1] = e[0] - e[1] + e[2] - e[3];
    s[2] = e[0] + e[1] - e[2] - e[3];
    s[3] = e[0] - e[1] - e[2] + e[3];
  end

  always_comb begin
    case (cmd_i.mul_sel)
      fdnr_pkg::MUL_TAP: begin
        op_a = fdnr_pkg::OPA_W'(d_q[cmd_i.line]);
        op_b = $signed(cfg_i.gain[cmd_i.line]);
      end
      fdnr_pkg::MUL_DRY: begin
        op_a = fdnr_pkg::OPA_W'(x_q);
        op_b = $signed(cfg_i.master);
      end
      fdnr_pkg::MUL_WET: begin
        op_a = wet_q;
        op_b = $signed(fdnr_pkg::GAIN_W'(fdnr_pkg::UNITY) - cfg_i.master);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign y_pre = fdnr_pkg::SAT_IN_W'($signed(acc_q[fdnr_pkg::ACC_W-1:fdnr_pkg::FRAC]));
  assign wsum  = (SW + 2)'(y_q) + (SW + 2)'(d_q[cmd_i.line]);
  assign wval  = fdnr_pkg::sat_sample(fdnr_pkg::SAT_IN_W'($signed(wsum[SW+1:1])));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q  <= sample_in_i;
      ch_q <= ch_d;
    end
    if (cmd_i.rd_en) begin
      rd_ok_q   <= rd_ok;
      rd_line_q <= cmd_i.line;
    end
    if (rd_pend_q) begin
      t_q[rd_line_q] <= rd_ok_q ? $signed(rdata_q) : '0;
    end
    if (cmd_i.had_en) begin
      for (int k = 0; k < fdnr_pkg::LINES; k++) begin
        d_q[k] <= s[k][SW+1:1];
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + fdnr_pkg::ACC_W'(prod_q);
    end
    if (cmd_i.wet_en) begin
      wet_q <= acc_q[fdnr_pkg::WET_W+fdnr_pkg::FRAC-1:fdnr_pkg::FRAC];
    end
    if (cmd_i.y_en) begin
      y_q <= fdnr_pkg::sat_sample(y_pre);
    end
    if (cmd_i.out_load) begin
      out_q <= y_q;
    end
  end

  assign sample_out_o = out_q;

endmodule

>>> rtl/fdn_reverb_four_line.sv
// ----------------------------------------------------------------------------
// fdn_reverb_four_line
// Stereo four-line feedback delay network reverb with Hadamard feedback mix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a channel bit and a Q1.15
//   sample; output channel (out_valid_o/out_ready_i) returns one mixed
//   sample per input transfer, in order.
//   Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always
//   ready; write them only while no sample is in flight.
//   Each sample passes, from input transfer to result, through the tap reads
//   of all four lines plus a drain step on the single-port delay store, a
//   Hadamard step, the shared 20x17 multiplier-accumulator for the line
//   gains, the dry/wet mix and write-back on the same store port.
//   A new sample is taken in the cycle after the result is loaded, so a
//   sample is not accepted until the previous one is finished.
//   The finished result sits in an output register; if the receiver stalls,
//   the next sample is still processed and waits in its last step until the
//   register is freed.
//   Reset restores the default delays and gains and zeroes the write
//   positions; taps not yet written since reset read as zero, so no clearing
//   pass runs and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module fdn_reverb_four_line (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 channel_i,
  input  logic signed [fdnr_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fdnr_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fdnr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fdnr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  fdnr_pkg::cfg_t     cfg;
  fdnr_pkg::ctl_cmd_t cmd;

  fdnr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fdnr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fdnr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o)
  );

endmodule
